[rtl/core/complex_log_polar_alu_defines.svh]
// Assertion macros for the complex log-polar ALU.
// Used by the top level; no other dependencies.
`ifndef COMPLEX_LOG_POLAR_ALU_DEFINES_SVH
`define COMPLEX_LOG_POLAR_ALU_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define CLPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clpa: same-cycle check failed");

// next-cycle implication, checked out of reset
`define CLPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clpa: next-cycle check failed");

`else

`define CLPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CLPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/clpa_pkg.sv]
// Shared types, constants and step functions of the complex log-polar ALU.
// Constant tables (ln(1+2^-i), atan(2^-i)) are built here at elaboration.
package clpa_pkg;

    localparam int ANGLE_W  = 16;
    localparam int LOG_FRAC = 16;
    localparam int LOG_W    = LOG_FRAC + 8;
    localparam int FR       = 48;

    localparam logic [63:0] ONE          = 64'h0001_0000_0000_0000;
    localparam logic [63:0] TWO_ONE      = 64'h0002_0000_0000_0000;
    localparam logic [63:0] TURN_HALF    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TURN_QUARTER = 64'h4000_0000_0000_0000;
    localparam logic [63:0] TWO_OVER_PI  = 64'hA2F9_836E_4E44_1529;
    localparam logic [63:0] ROUND_ANGLE  = 64'h0000_8000_0000_0000;
    localparam logic [63:0] ROUND_LOG    = 64'h0000_0000_8000_0000;
    localparam logic [23:0] LOG_MAX      = 24'h7F_FFFF;
    localparam logic [23:0] LOG_MIN      = 24'h80_0000;
    localparam logic [15:0] ANGLE_PI     = 16'h8000;

    typedef enum logic [2:0] {
        OP_MUL    = 3'd0,
        OP_DIV    = 3'd1,
        OP_ADD    = 3'd2,
        OP_SUB    = 3'd3,
        OP_LESS   = 3'd4,
        OP_EQUAL  = 3'd5,
        OP_NEGATE = 3'd6,
        OP_LOWER  = 3'd7
    } op_t;

    typedef enum logic {
        REG_TOL_LOG   = 1'b0,
        REG_TOL_ANGLE = 1'b1
    } reg_idx_t;

    // Per-item context carried down the pipeline
    typedef struct packed {
        logic        is_add;
        logic        special;   // exact zero of add/sub
        logic        tiny;      // exp underflow, weak operand vanishes
        logic        nonpos;    // vectoring magnitude not positive
        logic [15:0] r_angle;
        logic [23:0] r_logmag;
        logic        flag;
        logic        zero;
        logic        ovf;
        logic [15:0] da;
        logic [23:0] dl;
        logic [15:0] th;
        logic [5:0]  q;         // quotient, then exponent shift
        logic [5:0]  p;         // leading one position
        logic [63:0] n;         // remainder, then (p-48)*ln2
        logic [63:0] s;         // exp residual, product, rounded ln
        logic [63:0] ey;        // exp / log iterate
        logic [63:0] z;         // rotation angle, then vector angle
        logic [63:0] cx;
        logic [63:0] cy;
        logic [63:0] acc;
        logic [48:0] pp0;
        logic [48:0] pp1;
        logic [48:0] pp2;
        logic [48:0] pp3;
        logic [7:0]  grp_nz;
        logic [23:0] grp_pos;
    } clpa_ctx_t;

    // ------------------------------------------------------------------
    // Elaboration-time table construction
    // ------------------------------------------------------------------

    // floor(2^e / k), bit by bit
    function automatic logic [63:0] pow2_div(input int e, input int k);
        logic [63:0] num;
        logic [64:0] rem;
        logic [63:0] q;
        num = 64'd1 << e;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= 65'(k)) begin
                rem  = rem - 65'(k);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] ln2_calc();
        logic [63:0] acc;
        acc = '0;
        for (int k = 1; k <= 64; k++) begin
            acc = acc + pow2_div(64 - k, k);
        end
        return acc >> (64 - FR);
    endfunction

    localparam logic [63:0] LN2_FR = ln2_calc();

    // ln(1 + 2^-i)
    function automatic logic [63:0] lnt_entry(input int i);
        logic [63:0] acc;
        acc = '0;
        if (i == 0) begin
            return LN2_FR;
        end
        for (int k = 1; i * k < 64; k++) begin
            if ((k % 2) == 1) acc = acc + pow2_div(64 - i * k, k);
            else acc = acc - pow2_div(64 - i * k, k);
        end
        return acc >> (64 - FR);
    endfunction

    // atan(2^-i) as a fraction of a full turn, 2^64 = 2*pi
    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0]  acc;
        logic [127:0] full;
        acc = '0;
        if (i == 0) begin
            return 64'd1 << 61;
        end
        for (int k = 0; i * (2 * k + 1) < 64; k++) begin
            if ((k % 2) == 1) acc = acc - pow2_div(64 - i * (2 * k + 1), 2 * k + 1);
            else acc = acc + pow2_div(64 - i * (2 * k + 1), 2 * k + 1);
        end
        full = {64'd0, acc} * {64'd0, TWO_OVER_PI};
        return full[127:64] >> 2;
    endfunction

    function automatic longint ln_fix_const(input longint v, input int stages);
        int     p;
        longint y;
        longint t;
        longint acc;
        p = 0;
        for (int b = 1; b <= 62; b++) begin
            if (v[b]) p = b;
        end
        if (p > FR) y = v >> (p - FR);
        else y = v << (FR - p);
        acc = 0;
        for (int i = 1; i <= stages; i++) begin
            t = y + (y >> i);
            if (t <= longint'(TWO_ONE)) begin
                y   = t;
                acc = acc + longint'(lnt_entry(i));
            end
        end
        return longint'(p - FR) * longint'(LN2_FR)
            + (longint'(LN2_FR) - acc - ((longint'(TWO_ONE) - y) >>> 1));
    endfunction

    // log of the CORDIC gain
    function automatic logic [63:0] ln_gain_calc(input int stages);
        longint g;
        g = longint'(ONE);
        for (int i = 0; i < stages; i++) begin
            if (2 * i < 64) g = g + (g >> (2 * i));
        end
        return 64'(ln_fix_const(g, stages) >>> 1);
    endfunction

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------

    // clamp to the log magnitude range; {overflow, value}
    function automatic logic [24:0] sat_log(input logic signed [63:0] v);
        if (v > 64'sd8388607) return {1'b1, LOG_MAX};
        if (v < -64'sd8388608) return {1'b1, LOG_MIN};
        return {1'b0, v[23:0]};
    endfunction

    // one restoring step of the divide by ln2
    function automatic clpa_ctx_t div_step(input clpa_ctx_t c, input logic [2:0] b,
                                           input logic [63:0] ln2);
        clpa_ctx_t   r;
        logic [63:0] den;
        r   = c;
        den = ln2 << b;
        if (b == 3'd5) r.tiny = (c.n > ((ln2 << 6) - (ln2 << 1)));
        if (c.n >= den) begin
            r.n    = c.n - den;
            r.q[b] = 1'b1;
        end
        return r;
    endfunction

    // exponent shift and residual from quotient and remainder
    function automatic clpa_ctx_t fix_step(input clpa_ctx_t c, input logic [63:0] ln2);
        clpa_ctx_t r;
        r    = c;
        r.ey = ONE;
        if (c.n == '0) begin
            r.s = '0;
        end else begin
            r.q = c.q + 6'd1;
            r.s = ln2 - c.n;
        end
        return r;
    endfunction

    function automatic clpa_ctx_t exp_step(input clpa_ctx_t c, input int i,
                                           input logic [63:0] lnt);
        clpa_ctx_t r;
        r = c;
        if ($signed(c.s) >= $signed(lnt)) begin
            r.s  = c.s - lnt;
            r.ey = c.ey + (c.ey >> i);
        end
        return r;
    endfunction

    // partial products of y * s
    function automatic clpa_ctx_t mul1_step(input clpa_ctx_t c);
        clpa_ctx_t r;
        r     = c;
        r.pp0 = 49'({24'd0, c.ey[24:0]} * {25'd0, c.s[23:0]});
        r.pp1 = 49'({24'd0, c.ey[24:0]} * {25'd0, c.s[47:24]});
        r.pp2 = 49'({24'd0, c.ey[49:25]} * {25'd0, c.s[23:0]});
        r.pp3 = 49'({24'd0, c.ey[49:25]} * {25'd0, c.s[47:24]});
        return r;
    endfunction

    function automatic clpa_ctx_t mul2_step(input clpa_ctx_t c);
        clpa_ctx_t   r;
        logic [98:0] sum;
        r   = c;
        sum = {50'd0, c.pp0} + ({50'd0, c.pp1} << 24) + ({50'd0, c.pp2} << 25)
            + ({50'd0, c.pp3} << 49);
        r.s = 64'(sum >> 48);
        return r;
    endfunction

    function automatic clpa_ctx_t mul3_step(input clpa_ctx_t c);
        clpa_ctx_t r;
        r    = c;
        r.cx = c.tiny ? 64'd0 : ((c.ey + c.s) >> c.q);
        return r;
    endfunction

    // quadrant fold before rotation
    function automatic clpa_ctx_t rot_init(input clpa_ctx_t c);
        clpa_ctx_t   r;
        logic [63:0] zq;
        r    = c;
        r.z  = {c.th, 48'd0};
        r.cy = '0;
        zq   = r.z + TURN_QUARTER;
        if (zq[63]) begin
            r.cx = -c.cx;
            r.z  = r.z + TURN_HALF;
        end
        return r;
    endfunction

    function automatic clpa_ctx_t rot_step(input clpa_ctx_t c, input int i,
                                           input logic [63:0] atn);
        clpa_ctx_t          r;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        r  = c;
        sx = $signed(c.cy) >>> i;
        sy = $signed(c.cx) >>> i;
        if (!c.z[63]) begin
            r.cx = c.cx - sx;
            r.cy = c.cy + sy;
            r.z  = c.z - atn;
        end else begin
            r.cx = c.cx + sx;
            r.cy = c.cy - sy;
            r.z  = c.z + atn;
        end
        return r;
    endfunction

    // w = 1 + rotated vector, folded into the right half plane
    function automatic clpa_ctx_t vec_init(input clpa_ctx_t c);
        clpa_ctx_t   r;
        logic [63:0] vx;
        r  = c;
        vx = ONE + c.cx;
        if (vx[63]) begin
            r.cx = -vx;
            r.cy = -c.cy;
            r.z  = TURN_HALF;
        end else begin
            r.cx = vx;
            r.z  = '0;
        end
        return r;
    endfunction

    function automatic clpa_ctx_t vec_step(input clpa_ctx_t c, input int i,
                                           input logic [63:0] atn);
        clpa_ctx_t          r;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        r  = c;
        sx = $signed(c.cy) >>> i;
        sy = $signed(c.cx) >>> i;
        if (c.cy[63]) begin
            r.cx = c.cx - sx;
            r.cy = c.cy + sy;
            r.z  = c.z - atn;
        end else begin
            r.cx = c.cx + sx;
            r.cy = c.cy - sy;
            r.z  = c.z + atn;
        end
        return r;
    endfunction

    // leading one, first half: per-byte detect
    function automatic clpa_ctx_t lead1_step(input clpa_ctx_t c);
        clpa_ctx_t   r;
        logic [63:0] v;
        r      = c;
        v      = {1'b0, c.cx[62:0]};
        r.nonpos = c.cx[63] || (c.cx == '0);
        for (int g = 0; g < 8; g++) begin
            r.grp_nz[g]         = |v[8*g +: 8];
            r.grp_pos[3*g +: 3] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (v[8*g + b]) r.grp_pos[3*g +: 3] = 3'(b);
            end
        end
        return r;
    endfunction

    // leading one, second half: pick highest byte
    function automatic clpa_ctx_t lead2_step(input clpa_ctx_t c);
        clpa_ctx_t r;
        r   = c;
        r.p = '0;
        for (int g = 0; g < 8; g++) begin
            if (c.grp_nz[g]) r.p = {3'(g), c.grp_pos[3*g +: 3]};
        end
        return r;
    endfunction

    // normalize to [1,2) and form (p-48)*ln2
    function automatic clpa_ctx_t lead3_step(input clpa_ctx_t c, input logic [63:0] ln2);
        clpa_ctx_t          r;
        logic signed [6:0]  pd;
        logic signed [55:0] prod;
        r = c;
        if (c.p > 6'd48) r.ey = c.cx >> (c.p - 6'd48);
        else r.ey = c.cx << (6'd48 - c.p);
        pd    = $signed({1'b0, c.p}) - 7'sd48;
        prod  = pd * $signed({1'b0, ln2[47:0]});
        r.n   = 64'(prod);
        r.acc = '0;
        return r;
    endfunction

    function automatic clpa_ctx_t ln_step(input clpa_ctx_t c, input int i,
                                          input logic [63:0] lnt);
        clpa_ctx_t   r;
        logic [63:0] t;
        r = c;
        t = c.ey + (c.ey >> i);
        if ($signed(t) <= $signed(TWO_ONE)) begin
            r.ey  = t;
            r.acc = c.acc + lnt;
        end
        return r;
    endfunction

    // ln|w| rounded to log LSBs
    function automatic clpa_ctx_t fin1_step(input clpa_ctx_t c, input logic [63:0] ln2,
                                            input logic [63:0] gain);
        clpa_ctx_t          r;
        logic signed [63:0] lnv;
        logic signed [63:0] lw;
        r   = c;
        lnv = $signed(c.n) + $signed(ln2 - c.acc - 64'($signed(TWO_ONE - c.ey) >>> 1));
        lw  = lnv - $signed(gain);
        r.s = 64'((lw + $signed(ROUND_LOG)) >>> 32);
        return r;
    endfunction

    // result assembly
    function automatic clpa_ctx_t fin2_step(input clpa_ctx_t c);
        clpa_ctx_t   r;
        logic [63:0] ra;
        logic [24:0] sat;
        r   = c;
        ra  = c.z + ROUND_ANGLE;
        sat = sat_log($signed({{40{c.dl[23]}}, c.dl}) + $signed(c.s));
        if (c.is_add && !c.special) begin
            r.r_angle = c.da + ra[63:48];
            r.zero    = 1'b0;
            if (c.nonpos) begin
                r.r_logmag = LOG_MIN;
                r.ovf      = 1'b1;
            end else begin
                r.r_logmag = sat[23:0];
                r.ovf      = sat[24];
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/complex_log_polar_alu.sv]
// Complex log-polar ALU: one operation per cycle through a fixed pipeline of
// 4*CORDIC_STAGES+18 register stages (98 at the default). The depth is set by
// the four chained shift-add units of add/subtract (exp, rotating CORDIC,
// vectoring CORDIC, log), one iteration per stage; all operations take the
// same path so results leave in order. A new item is taken every cycle; a
// held result freezes the whole pipe, so in_stall follows out_stall only while
// a result waits. Tolerance writes take effect on items accepted afterwards.
// Depends on clpa_pkg and complex_log_polar_alu_defines.svh.
`include "complex_log_polar_alu_defines.svh"

module complex_log_polar_alu #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // operation in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [15:0] a_angle,
    input  logic [23:0] a_logmag,
    input  logic [15:0] b_angle,
    input  logic [23:0] b_logmag,
    // result out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] r_angle,
    output logic [23:0] r_logmag,
    output logic        flag,
    output logic        zero,
    output logic        overflow
);

    localparam int S       = CORDIC_STAGES;
    localparam int I_DIV   = 1;
    localparam int I_FIX   = 7;
    localparam int I_EXP   = 8;
    localparam int I_M1    = I_EXP + S;
    localparam int I_M2    = I_M1 + 1;
    localparam int I_M3    = I_M2 + 1;
    localparam int I_RINIT = I_M3 + 1;
    localparam int I_ROT   = I_RINIT + 1;
    localparam int I_VINIT = I_ROT + S;
    localparam int I_VEC   = I_VINIT + 1;
    localparam int I_L1    = I_VEC + S;
    localparam int I_L2    = I_L1 + 1;
    localparam int I_L3    = I_L2 + 1;
    localparam int I_LN    = I_L3 + 1;
    localparam int I_F1    = I_LN + S;
    localparam int I_F2    = I_F1 + 1;
    localparam int DEPTH   = I_F2 + 1;

    localparam logic [63:0] LN2     = clpa_pkg::LN2_FR;
    localparam logic [63:0] LN_GAIN = clpa_pkg::ln_gain_calc(S);

    logic [15:0] tol_log_reg;
    logic [14:0] tol_angle_reg;

    logic [DEPTH-1:0]    vld_reg;
    clpa_pkg::clpa_ctx_t ctx_reg  [DEPTH];
    clpa_pkg::clpa_ctx_t ctx_next [DEPTH];
    clpa_pkg::clpa_ctx_t front;
    logic                adv;

    // front-end locals
    logic [24:0] sum_mul;
    logic [24:0] sum_div;
    logic [15:0] bb_angle;
    logic        a_dom;
    logic [15:0] dom_angle;
    logic [15:0] weak_angle;
    logic [23:0] dom_log;
    logic [23:0] weak_log;
    logic [24:0] d_log;
    logic [24:0] neg_d;
    logic [24:0] dl_ab;
    logic [24:0] dl_abs;
    logic [15:0] dang;
    logic [16:0] dang_abs;
    logic [25:0] b_minus_tol;
    logic [17:0] ba_minus_tol;
    logic [24:0] sat_mul;
    logic [24:0] sat_div;

    // ------------------------------------------------------------------
    // Tolerance registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_log_reg   <= 16'd1;
            tol_angle_reg <= 15'd1;
        end
        else if (cfg_write)
        begin
            case (clpa_pkg::reg_idx_t'(cfg_index))
                clpa_pkg::REG_TOL_LOG:   tol_log_reg   <= cfg_data;
                clpa_pkg::REG_TOL_ANGLE: tol_angle_reg <= cfg_data[14:0];
                default:                 tol_log_reg   <= tol_log_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: simple ops complete here, add/sub set up
    // ------------------------------------------------------------------
    always_comb
    begin
        front = '0;

        sum_mul = {a_logmag[23], a_logmag} + {b_logmag[23], b_logmag};
        sum_div = {a_logmag[23], a_logmag} - {b_logmag[23], b_logmag};
        sat_mul = clpa_pkg::sat_log(64'($signed(sum_mul)));
        sat_div = clpa_pkg::sat_log(64'($signed(sum_div)));

        // dominant operand: larger log magnitude, a on ties
        bb_angle = (clpa_pkg::op_t'(operation) == clpa_pkg::OP_SUB) ?
                   b_angle + clpa_pkg::ANGLE_PI : b_angle;
        a_dom      = !($signed(a_logmag) < $signed(b_logmag));
        dom_angle  = a_dom ? a_angle  : bb_angle;
        weak_angle = a_dom ? bb_angle : a_angle;
        dom_log    = a_dom ? a_logmag : b_logmag;
        weak_log   = a_dom ? b_logmag : a_logmag;
        d_log      = {weak_log[23], weak_log} - {dom_log[23], dom_log};
        neg_d      = -d_log;

        // compare helpers
        dl_ab        = sum_div;
        dl_abs       = dl_ab[24] ? -dl_ab : dl_ab;
        dang         = a_angle - b_angle;
        dang_abs     = dang[15] ? -{dang[15], dang} : {1'b0, dang};
        b_minus_tol  = {{2{b_logmag[23]}}, b_logmag} - {10'd0, tol_log_reg};
        ba_minus_tol = {{2{b_angle[15]}}, b_angle} - {3'd0, tol_angle_reg};

        case (clpa_pkg::op_t'(operation))
            clpa_pkg::OP_MUL:
            begin
                front.r_angle  = a_angle + b_angle;
                front.r_logmag = sat_mul[23:0];
                front.ovf      = sat_mul[24];
            end
            clpa_pkg::OP_DIV:
            begin
                front.r_angle  = a_angle - b_angle;
                front.r_logmag = sat_div[23:0];
                front.ovf      = sat_div[24];
            end
            clpa_pkg::OP_ADD, clpa_pkg::OP_SUB:
            begin
                front.is_add = 1'b1;
                front.da     = dom_angle;
                front.dl     = dom_log;
                front.th     = weak_angle - dom_angle;
                front.n      = ({39'd0, neg_d} << 32) + LN_GAIN;
                // equal magnitudes, opposite angles: exact zero
                if (d_log == '0 && front.th == clpa_pkg::ANGLE_PI)
                begin
                    front.special  = 1'b1;
                    front.r_angle  = '0;
                    front.r_logmag = clpa_pkg::LOG_MIN;
                    front.zero     = 1'b1;
                end
            end
            clpa_pkg::OP_LESS:
            begin
                if ($signed({{2{a_logmag[23]}}, a_logmag}) < $signed(b_minus_tol))
                    front.flag = 1'b1;
                else if (dl_abs < {9'd0, tol_log_reg})
                    front.flag = $signed({{2{a_angle[15]}}, a_angle}) <
                                 $signed(ba_minus_tol);
                else
                    front.flag = 1'b0;
            end
            clpa_pkg::OP_EQUAL:
            begin
                front.flag = (dang_abs < {2'd0, tol_angle_reg}) &&
                             (dl_abs < {9'd0, tol_log_reg});
            end
            clpa_pkg::OP_NEGATE:
            begin
                front.r_angle  = a_angle + clpa_pkg::ANGLE_PI;
                front.r_logmag = a_logmag;
            end
            clpa_pkg::OP_LOWER:
            begin
                front.flag = a_angle[15];
            end
            default:
            begin
                front.flag = 1'b0;
            end
        endcase
    end

    assign ctx_next[0] = front;

    // ------------------------------------------------------------------
    // exp(d - ln gain): divide by ln2, then shift-add iterations
    // ------------------------------------------------------------------
    for (genvar j = 0; j < 6; j++)
    begin : g_div
        assign ctx_next[I_DIV+j] = clpa_pkg::div_step(ctx_reg[I_DIV+j-1], 3'(5 - j), LN2);
    end

    assign ctx_next[I_FIX] = clpa_pkg::fix_step(ctx_reg[I_FIX-1], LN2);

    for (genvar j = 0; j < S; j++)
    begin : g_exp
        localparam logic [63:0] LNT_I = clpa_pkg::lnt_entry(j + 1);
        assign ctx_next[I_EXP+j] = clpa_pkg::exp_step(ctx_reg[I_EXP+j-1], j + 1, LNT_I);
    end

    // residual correction y*s split over partial products
    assign ctx_next[I_M1] = clpa_pkg::mul1_step(ctx_reg[I_M1-1]);
    assign ctx_next[I_M2] = clpa_pkg::mul2_step(ctx_reg[I_M2-1]);
    assign ctx_next[I_M3] = clpa_pkg::mul3_step(ctx_reg[I_M3-1]);

    // ------------------------------------------------------------------
    // Rotate exp(d) by the angle difference
    // ------------------------------------------------------------------
    assign ctx_next[I_RINIT] = clpa_pkg::rot_init(ctx_reg[I_RINIT-1]);

    for (genvar j = 0; j < S; j++)
    begin : g_rot
        localparam logic [63:0] ATAN_I = clpa_pkg::atan_entry(j);
        assign ctx_next[I_ROT+j] = clpa_pkg::rot_step(ctx_reg[I_ROT+j-1], j, ATAN_I);
    end

    // ------------------------------------------------------------------
    // Vector 1 + w to magnitude and angle
    // ------------------------------------------------------------------
    assign ctx_next[I_VINIT] = clpa_pkg::vec_init(ctx_reg[I_VINIT-1]);

    for (genvar j = 0; j < S; j++)
    begin : g_vec
        localparam logic [63:0] ATAN_I = clpa_pkg::atan_entry(j);
        assign ctx_next[I_VEC+j] = clpa_pkg::vec_step(ctx_reg[I_VEC+j-1], j, ATAN_I);
    end

    // ------------------------------------------------------------------
    // ln of the magnitude: normalize, then shift-add iterations
    // ------------------------------------------------------------------
    assign ctx_next[I_L1] = clpa_pkg::lead1_step(ctx_reg[I_L1-1]);
    assign ctx_next[I_L2] = clpa_pkg::lead2_step(ctx_reg[I_L2-1]);
    assign ctx_next[I_L3] = clpa_pkg::lead3_step(ctx_reg[I_L3-1], LN2);

    for (genvar j = 0; j < S; j++)
    begin : g_ln
        localparam logic [63:0] LNT_I = clpa_pkg::lnt_entry(j + 1);
        assign ctx_next[I_LN+j] = clpa_pkg::ln_step(ctx_reg[I_LN+j-1], j + 1, LNT_I);
    end

    // ------------------------------------------------------------------
    // Round, add to the dominant operand, saturate
    // ------------------------------------------------------------------
    assign ctx_next[I_F1] = clpa_pkg::fin1_step(ctx_reg[I_F1-1], LN2, LN_GAIN);
    assign ctx_next[I_F2] = clpa_pkg::fin2_step(ctx_reg[I_F2-1]);

    // ------------------------------------------------------------------
    // Pipeline registers; a held result freezes every stage
    // ------------------------------------------------------------------
    assign adv      = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                ctx_reg[k] <= ctx_next[k];
            end
        end
    end

    // result port
    assign out_valid = vld_reg[DEPTH-1];
    assign r_angle   = ctx_reg[DEPTH-1].r_angle;
    assign r_logmag  = ctx_reg[DEPTH-1].r_logmag;
    assign flag      = ctx_reg[DEPTH-1].flag;
    assign zero      = ctx_reg[DEPTH-1].zero;
    assign overflow  = ctx_reg[DEPTH-1].ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CLPA_ASSERT_IMPLY(a_ovf_at_limit, clk, rst_n, out_valid && overflow, r_logmag == clpa_pkg::LOG_MAX || r_logmag == clpa_pkg::LOG_MIN)
    `CLPA_ASSERT_IMPLY(a_zero_form, clk, rst_n, out_valid && zero, r_logmag == clpa_pkg::LOG_MIN && r_angle == '0 && !overflow && !flag)
    `CLPA_ASSERT_IMPLY(a_flag_alone, clk, rst_n, out_valid && flag, r_logmag == '0 && r_angle == '0 && !overflow)
    `CLPA_ASSERT_NEXT(a_pipe_frozen, clk, rst_n, out_valid && out_stall, vld_reg == $past(vld_reg))

endmodule
